/* rtl/rcsm_pkg.sv */
// rcsm_pkg: shared widths, codes and helper functions of the random cyclic
// spline modulator (generator step, fixed-point weights, register indexes)
// no dependencies
package rcsm_pkg;

  // field widths
  localparam int KIND_W     = 2;
  localparam int PROG_W     = 16;
  localparam int SEED_W     = 32;
  localparam int PCNT_W     = 5;
  localparam int ACNT_W     = 16;
  localparam int PT_W       = 24;
  localparam int CURVE_W    = 17;
  localparam int ANCHOR_W   = 16;

  // port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // signed width of the spline coefficients and Horner partial sums
  localparam int HW         = 30;

  // smoothing weights, Q0.16
  localparam logic [13:0] W_OUTER  = 14'd14418;
  localparam logic [15:0] W_CENTRE = 16'd36700;
  localparam logic [15:0] SM_ROUND = 16'd32768;

  // point count limits
  localparam int MIN_POINTS   = 5;
  localparam int RESET_POINTS = 11;

  // evaluate output clamp and rounding
  localparam logic [CURVE_W-1:0] CURVE_MAX = 17'd65536;
  localparam int                 EV_ROUND  = 256;
  localparam int                 EV_SHIFT  = 9;

  // input kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RESEED = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_EVAL   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACNT = 2'd2;

  // one xorshift32 step, shifts 13 / 17 / 5
  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] v;
    begin
      v = s;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
    end
  endfunction

endpackage

/* rtl/rcsm_ram.sv */
// rcsm_ram: generic single-write, single-read synchronous RAM
// registered read data; no dependencies
module rcsm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 19
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rcsm_div.sv */
// rcsm_div: restoring remainder unit, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle; depends on rcsm_pkg
module rcsm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rcsm_pkg::SEED_W-1:0]   dividend,
  input  logic [rcsm_pkg::ACNT_W-1:0]   divisor,
  output logic                          done,
  output logic [rcsm_pkg::ACNT_W-1:0]   remainder
);

  localparam int DW = rcsm_pkg::SEED_W;
  localparam int RW = rcsm_pkg::ACNT_W;
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [RW-1:0] dvs_r;
  logic [RW-1:0] rem_r;
  logic [RW:0]   trial;
  logic [RW-1:0] rem_nxt;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = RW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[RW-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* rtl/random_cyclic_spline_modulator_unit.sv */
// random_cyclic_spline_modulator_unit: top level, sequencer around the point
// table and smoothing scratch RAMs; depends on rcsm_pkg, rcsm_ram, rcsm_div
//
// Smooth random periodic modulation curve. An input transfer carries a kind
// in in_tuser and a Q0.16 progress in in_tdata; each one gives exactly one
// output transfer. Reseed loads the xorshift32 generator from the seed
// register (zero loads one). Build draws point_count Q0.24 control points
// (clamped to 5..MAX_POINTS) into the point table, runs two circular
// 0.22/0.56/0.22 smoothing passes between the table and a scratch RAM, and
// returns an anchor offset drawn modulo anchor_count; the single read port is
// walked once per point and pass, and the bit-serial remainder unit runs
// when anchor_count is not zero. Evaluate reads four neighbouring points
// through the same single read port and runs three Horner steps on one
// shared multiplier. One item is in work at a time; the next one is taken
// while a finished result waits in the output register. The point table
// reads as zero until the first build, using one valid flag per entry;
// configuration must be written only while the block is idle, which the
// block itself does not enforce.
module random_cyclic_spline_modulator_unit #(
  parameter int MAX_POINTS = 19
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rcsm_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] progress
  input  logic [rcsm_pkg::KIND_W-1:0]        in_tuser,   // [1:0] kind
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rcsm_pkg::OUT_DATA_W-1:0]    out_tdata,  // [16:0] curve_value,
                                                         // [32:17] anchor_offset
  // configuration write port
  input  logic                               cfg_we,
  input  logic [rcsm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rcsm_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 3);
  localparam int PT_W      = rcsm_pkg::PT_W;
  localparam int HW        = rcsm_pkg::HW;
  localparam int PROG_W    = rcsm_pkg::PROG_W;
  localparam int PW        = PROG_W + CNT_W;
  localparam int MW        = HW + PROG_W + 1;
  localparam int SM_W      = PT_W + 17;
  localparam int CNT_RST_I = (MAX_POINTS < rcsm_pkg::RESET_POINTS) ?
                             MAX_POINTS : rcsm_pkg::RESET_POINTS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW,
    S_SMOOTH,
    S_ANCHOR,
    S_DIV,
    S_EV_POS,
    S_EV_READ,
    S_EV_LAST,
    S_EV_COEF,
    S_EV_MUL,
    S_EV_ADD,
    S_EV_FIN,
    S_RESULT
  } state_t;

  // control state
  state_t                         state_r;
  logic [rcsm_pkg::SEED_W-1:0]    seed_r;
  logic [rcsm_pkg::PCNT_W-1:0]    pcount_r;
  logic [rcsm_pkg::ACNT_W-1:0]    acount_r;
  logic [rcsm_pkg::SEED_W-1:0]    gen_r;
  logic [CNT_W-1:0]               cnt_act_r;
  logic [MAX_POINTS-1:0]          tvld_r;
  logic                           out_valid_r;
  logic                           pass_r;
  logic [CNT_W-1:0]               rd_cnt_r;
  logic                           d1_v_r;
  logic                           s_v_r;
  logic                           ev_rv_r;

  // payload
  logic [CNT_W-1:0]               d1_k_r;
  logic                           tvld_rd_r;
  logic [PT_W-1:0]                win_a_r;
  logic [PT_W-1:0]                win_b_r;
  logic [IDX_W-1:0]               s_i_r;
  logic [SM_W-1:0]                po_r;
  logic [SM_W-1:0]                pc_r;
  logic [PROG_W-1:0]              prog_r;
  logic [CNT_W-1:0]               base_r;
  logic [PROG_W-1:0]              t_r;
  logic [1:0]                     ev_k_r;
  logic [1:0]                     ev_rk_r;
  logic [PT_W-1:0]                ev_p_r [4];
  logic signed [HW-1:0]           h_r;
  logic signed [HW-1:0]           b_r;
  logic signed [HW-1:0]           c_r;
  logic signed [HW-1:0]           p1x2_r;
  logic signed [MW-1:0]           mul_r;
  logic [1:0]                     step_r;
  logic [rcsm_pkg::CURVE_W-1:0]   res_curve_r;
  logic [rcsm_pkg::ANCHOR_W-1:0]  res_anchor_r;
  logic [rcsm_pkg::OUT_DATA_W-1:0] out_data_r;

  // combinational
  logic [CNT_W-1:0]               n_build;
  logic [rcsm_pkg::SEED_W-1:0]    gen_nxt;
  logic                           sm_issue;
  logic [CNT_W-1:0]               sm_addr;
  logic [CNT_W-1:0]               ev_addr;
  logic [IDX_W-1:0]               tbl_raddr;
  logic                           tbl_we;
  logic [IDX_W-1:0]               tbl_waddr;
  logic [PT_W-1:0]                tbl_wdata;
  logic                           scr_we;
  logic [PT_W-1:0]                tbl_rdata;
  logic [PT_W-1:0]                scr_rdata;
  logic [PT_W-1:0]                tbl_rd_eff;
  logic [PT_W-1:0]                rd_eff;
  logic [PT_W:0]                  sm_outer;
  logic [SM_W-1:0]                sm_sum;
  logic [PW-1:0]                  pos;
  logic signed [HW-1:0]           sx [4];
  logic signed [HW-1:0]           coef_a;
  logic signed [HW-1:0]           coef_b;
  logic signed [HW-1:0]           coef_c;
  logic signed [HW-1:0]           addend;
  logic signed [HW-1:0]           fin;
  logic                           out_load;
  logic                           div_start;
  logic                           div_done;
  logic [rcsm_pkg::ACNT_W-1:0]    div_rem;

  // build point count, clamped to the legal range
  always_comb begin
    if (32'(pcount_r) < rcsm_pkg::MIN_POINTS) begin
      n_build = CNT_W'(rcsm_pkg::MIN_POINTS);
    end else if (32'(pcount_r) > MAX_POINTS) begin
      n_build = CNT_W'(MAX_POINTS);
    end else begin
      n_build = CNT_W'(pcount_r);
    end
  end

  assign gen_nxt = rcsm_pkg::xorshift32(gen_r);

  // smoothing read walk: n-1, 0, 1, .., n-1, 0
  always_comb begin
    sm_issue = (state_r == S_SMOOTH) && (rd_cnt_r != cnt_act_r + CNT_W'(2));
    if (rd_cnt_r == '0) begin
      sm_addr = cnt_act_r - CNT_W'(1);
    end else if (rd_cnt_r == cnt_act_r + CNT_W'(1)) begin
      sm_addr = '0;
    end else begin
      sm_addr = rd_cnt_r - CNT_W'(1);
    end
  end

  // evaluate neighbour addresses, base-1 .. base+2 around the loop
  always_comb begin
    unique case (ev_k_r)
      2'd0: ev_addr = (base_r == '0) ? cnt_act_r - CNT_W'(1) : base_r - CNT_W'(1);
      2'd1: ev_addr = base_r;
      2'd2: ev_addr = (base_r + CNT_W'(1) == cnt_act_r) ? '0 : base_r + CNT_W'(1);
      default: begin
        if (base_r + CNT_W'(2) >= cnt_act_r) begin
          ev_addr = base_r + CNT_W'(2) - cnt_act_r;
        end else begin
          ev_addr = base_r + CNT_W'(2);
        end
      end
    endcase
  end

  // memory port steering
  always_comb begin
    tbl_raddr = (state_r == S_SMOOTH) ? sm_addr[IDX_W-1:0] : ev_addr[IDX_W-1:0];
    tbl_we    = (state_r == S_DRAW) || (s_v_r && pass_r);
    scr_we    = s_v_r && !pass_r;
    if (state_r == S_DRAW) begin
      tbl_waddr = rd_cnt_r[IDX_W-1:0];
      tbl_wdata = gen_nxt[PT_W-1:0];
    end else begin
      tbl_waddr = s_i_r;
      tbl_wdata = sm_sum[PT_W+15:16];
    end
  end

  // unwritten table entries read as zero
  assign tbl_rd_eff = tvld_rd_r ? tbl_rdata : '0;
  assign rd_eff     = pass_r ? scr_rdata : tbl_rd_eff;
  assign sm_outer   = {1'b0, win_a_r} + {1'b0, rd_eff};
  assign sm_sum     = po_r + pc_r + SM_W'(rcsm_pkg::SM_ROUND);

  // evaluate position and spline coefficients (doubled, exact)
  always_comb begin
    pos = PW'(prog_r) * PW'(cnt_act_r);
    for (int i = 0; i < 4; i++) begin
      sx[i] = $signed({{(HW-PT_W){1'b0}}, ev_p_r[i]});
    end
    coef_a = sx[3] - sx[0] + ((sx[1] - sx[2]) <<< 1) + (sx[1] - sx[2]);
    coef_b = (sx[0] <<< 1) - ((sx[1] <<< 2) + sx[1]) + (sx[2] <<< 2) - sx[3];
    coef_c = sx[2] - sx[0];
    unique case (step_r)
      2'd0:    addend = b_r;
      2'd1:    addend = c_r;
      default: addend = p1x2_r;
    endcase
    fin = (h_r + HW'(rcsm_pkg::EV_ROUND)) >>> rcsm_pkg::EV_SHIFT;
  end

  assign out_load  = (state_r == S_RESULT) && (!out_valid_r || out_tready);
  assign div_start = (state_r == S_ANCHOR) && (acount_r != '0);

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= rcsm_pkg::SEED_W'(1);
      pcount_r    <= rcsm_pkg::PCNT_W'(rcsm_pkg::RESET_POINTS);
      acount_r    <= '0;
      gen_r       <= rcsm_pkg::SEED_W'(1);
      cnt_act_r   <= CNT_W'(CNT_RST_I);
      tvld_r      <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      rd_cnt_r    <= '0;
      d1_v_r      <= 1'b0;
      s_v_r       <= 1'b0;
      ev_rv_r     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          rcsm_pkg::CFG_SEED: seed_r   <= cfg_wdata[rcsm_pkg::SEED_W-1:0];
          rcsm_pkg::CFG_PCNT: pcount_r <= cfg_wdata[rcsm_pkg::PCNT_W-1:0];
          rcsm_pkg::CFG_ACNT: acount_r <= cfg_wdata[rcsm_pkg::ACNT_W-1:0];
          default: ;
        endcase
      end

      // read return and smoothing pipeline
      tvld_rd_r <= tvld_r[tbl_raddr];
      d1_v_r    <= sm_issue;
      d1_k_r    <= rd_cnt_r;
      s_v_r     <= d1_v_r && (d1_k_r >= CNT_W'(2));
      if (d1_v_r) begin
        win_a_r <= win_b_r;
        win_b_r <= rd_eff;
        s_i_r   <= IDX_W'(d1_k_r - CNT_W'(2));
        po_r    <= SM_W'(rcsm_pkg::W_OUTER) * SM_W'(sm_outer);
        pc_r    <= SM_W'(rcsm_pkg::W_CENTRE) * SM_W'(win_b_r);
      end
      if (tbl_we) begin
        tvld_r[tbl_waddr] <= 1'b1;
      end

      // evaluate point capture
      ev_rv_r <= (state_r == S_EV_READ);
      ev_rk_r <= ev_k_r;
      if (ev_rv_r) begin
        ev_p_r[ev_rk_r] <= tbl_rd_eff;
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= rcsm_pkg::OUT_DATA_W'({res_anchor_r, res_curve_r});
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            res_curve_r  <= '0;
            res_anchor_r <= '0;
            prog_r       <= in_tdata[PROG_W-1:0];
            unique case (rcsm_pkg::kind_t'(in_tuser))
              rcsm_pkg::KIND_RESEED: begin
                gen_r   <= (seed_r == '0) ? rcsm_pkg::SEED_W'(1) : seed_r;
                state_r <= S_RESULT;
              end
              rcsm_pkg::KIND_BUILD: begin
                cnt_act_r <= n_build;
                rd_cnt_r  <= '0;
                state_r   <= S_DRAW;
              end
              rcsm_pkg::KIND_EVAL: begin
                state_r <= S_EV_POS;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end

        // one draw per control point
        S_DRAW: begin
          gen_r <= gen_nxt;
          if (rd_cnt_r == cnt_act_r - CNT_W'(1)) begin
            rd_cnt_r <= '0;
            pass_r   <= 1'b0;
            state_r  <= S_SMOOTH;
          end else begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
        end

        // table to scratch, then scratch back to table
        S_SMOOTH: begin
          if (sm_issue) begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
          if (s_v_r && (s_i_r == IDX_W'(cnt_act_r - CNT_W'(1)))) begin
            rd_cnt_r <= '0;
            if (!pass_r) begin
              pass_r <= 1'b1;
            end else begin
              pass_r  <= 1'b0;
              state_r <= S_ANCHOR;
            end
          end
        end

        S_ANCHOR: begin
          if (acount_r == '0) begin
            state_r <= S_RESULT;
          end else begin
            gen_r   <= gen_nxt;
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            res_anchor_r <= div_rem;
            state_r      <= S_RESULT;
          end
        end

        S_EV_POS: begin
          base_r  <= pos[PW-1:PROG_W];
          t_r     <= pos[PROG_W-1:0];
          ev_k_r  <= '0;
          state_r <= S_EV_READ;
        end

        S_EV_READ: begin
          ev_k_r <= ev_k_r + 2'd1;
          if (ev_k_r == 2'd3) begin
            state_r <= S_EV_LAST;
          end
        end

        S_EV_LAST: begin
          state_r <= S_EV_COEF;
        end

        S_EV_COEF: begin
          h_r     <= coef_a;
          b_r     <= coef_b;
          c_r     <= coef_c;
          p1x2_r  <= sx[1] <<< 1;
          step_r  <= '0;
          state_r <= S_EV_MUL;
        end

        // shared multiplier, one Horner step per multiply/add pair
        S_EV_MUL: begin
          mul_r   <= h_r * $signed({1'b0, t_r});
          state_r <= S_EV_ADD;
        end

        S_EV_ADD: begin
          h_r <= HW'(mul_r >>> PROG_W) + addend;
          if (step_r == 2'd2) begin
            state_r <= S_EV_FIN;
          end else begin
            step_r  <= step_r + 2'd1;
            state_r <= S_EV_MUL;
          end
        end

        // round to Q0.16 and clamp
        S_EV_FIN: begin
          if (fin < 0) begin
            res_curve_r <= '0;
          end else if (fin > $signed(HW'(rcsm_pkg::CURVE_MAX))) begin
            res_curve_r <= rcsm_pkg::CURVE_MAX;
          end else begin
            res_curve_r <= fin[rcsm_pkg::CURVE_W-1:0];
          end
          state_r <= S_RESULT;
        end

        S_RESULT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // point table and smoothing scratch
  rcsm_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rcsm_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_scr (
    .clk   (clk),
    .we    (scr_we),
    .waddr (s_i_r),
    .wdata (sm_sum[PT_W+15:16]),
    .raddr (sm_addr[IDX_W-1:0]),
    .rdata (scr_rdata)
  );

  // anchor offset remainder
  rcsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (gen_nxt),
    .divisor   (acount_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
